/* rtl/core/tdre_pkg.sv */
// Shared types, codes and helpers of the tag-delimited record extractor.
`timescale 1ns / 1ps
`default_nettype none

package tdre_pkg;

   localparam int CsrIndexW = 2;
   localparam int TagBytesW = 64;
   localparam int TagLenW   = 4;

   // Register indexes of the configuration port
   localparam logic [CsrIndexW-1:0] CsrStartTagBytes  = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrStartTagLength = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrEndTagBytes    = 2'd2;
   localparam logic [CsrIndexW-1:0] CsrEndTagLength   = 2'd3;

   // Result kinds
   localparam logic [1:0] KindContent      = 2'd0;
   localparam logic [1:0] KindRecordEnd    = 2'd1;
   localparam logic [1:0] KindUnterminated = 2'd2;

   typedef struct packed {
      logic [TagBytesW-1:0] start_bytes;
      logic [TagLenW-1:0]   start_len;
      logic [TagBytesW-1:0] end_bytes;
      logic [TagLenW-1:0]   end_len;
   } tag_cfg_type;

   typedef struct packed {
      logic                 shift;
      logic                 clear;
      logic                 trunc;
      logic [TagLenW-1:0]   keep_len;
   } cell_ctrl_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       start_hit;
      logic       end_hit;
   } cell_stat_type;

   // Zero acts as one, anything above the window size acts as the window size
   function automatic logic [TagLenW-1:0] eff_len(input logic [TagLenW-1:0] len,
                                                  input logic [TagLenW-1:0] max_len);
      logic [TagLenW-1:0] res;
      res = len;
      if (len == '0) res = {{(TagLenW-1){1'b0}}, 1'b1};
      else if (len > max_len) res = max_len;
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/tdre_req_if.sv */
// Input byte channel of the record extractor.
`timescale 1ns / 1ps
`default_nettype none

interface tdre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

`default_nettype wire

/* rtl/core/tdre_rsp_if.sv */
// Result channel of the record extractor.
`timescale 1ns / 1ps
`default_nettype none

interface tdre_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] content_byte;

   modport source (output valid, output result_kind, output content_byte, input ready);
   modport sink   (input valid, input result_kind, input content_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/tdre_csr_if.sv */
// Configuration write channel of the record extractor.
`timescale 1ns / 1ps
`default_nettype none

interface tdre_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tdre_pkg::CsrIndexW-1:0]  index;
   logic [tdre_pkg::TagBytesW-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/tdre_csr.sv */
// Configuration registers for the start and end patterns.
`timescale 1ns / 1ps
`default_nettype none

module tdre_csr (
   input  wire                    clock,
   input  wire                    reset,
   tdre_csr_if.sink               csr_if,
   output tdre_pkg::tag_cfg_type  cfg
);

   tdre_pkg::tag_cfg_type cfg_ff;
   tdre_pkg::tag_cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            tdre_pkg::CsrStartTagBytes:  cfg_in.start_bytes = csr_if.data;
            tdre_pkg::CsrStartTagLength: cfg_in.start_len   = csr_if.data[tdre_pkg::TagLenW-1:0];
            tdre_pkg::CsrEndTagBytes:    cfg_in.end_bytes   = csr_if.data;
            tdre_pkg::CsrEndTagLength:   cfg_in.end_len     = csr_if.data[tdre_pkg::TagLenW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_bytes <= '0;
         cfg_ff.start_len   <= 4'd1;
         cfg_ff.end_bytes   <= '0;
         cfg_ff.end_len     <= 4'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tdre_cell.sv */
// One window cell: holds the byte of one age and checks it against both patterns.
`timescale 1ns / 1ps
`default_nettype none

module tdre_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire  [7:0]               byte_in,
   input  wire                      valid_in,
   input  wire tdre_pkg::tag_cfg_type    cfg,
   input  wire tdre_pkg::cell_ctrl_type  ctrl,
   output tdre_pkg::cell_stat_type  stat
);

   localparam logic [tdre_pkg::TagLenW-1:0] CellPos = tdre_pkg::TagLenW'(CELL_INDEX);

   logic [7:0]                    data_ff;
   logic                          valid_ff;
   logic                          valid_in_q;
   logic [tdre_pkg::TagLenW-1:0]  start_off;
   logic [tdre_pkg::TagLenW-1:0]  end_off;
   logic [7:0]                    start_pat;
   logic [7:0]                    end_pat;

   // Pattern byte that lines up with this age once the incoming byte lands here
   assign start_off = cfg.start_len - 4'd1 - CellPos;
   assign end_off   = cfg.end_len - 4'd1 - CellPos;
   assign start_pat = cfg.start_bytes[{start_off[2:0], 3'b000} +: 8];
   assign end_pat   = cfg.end_bytes[{end_off[2:0], 3'b000} +: 8];

   assign stat.data      = data_ff;
   assign stat.valid     = valid_ff;
   assign stat.start_hit = (CellPos >= cfg.start_len) || (byte_in == start_pat);
   assign stat.end_hit   = (CellPos >= cfg.end_len) || (byte_in == end_pat);

   // Drop ages beyond the hold window after a content byte leaves
   assign valid_in_q = valid_in && !(ctrl.trunc && (CellPos >= ctrl.keep_len));

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         data_ff <= byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= valid_in_q;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tag_delimited_record_extractor_core.sv */
// Top level of the tag-delimited record extractor.
// Usage: bytes enter on req_if, one beat per byte; a beat with stream_end set marks the
// end of input and carries no byte. Results leave on rsp_if: a content byte, a record-end
// marker, or an unterminated-record error when the input ends inside an open record.
// Patterns and their lengths are written through csr_if (index 0..3) while the block is idle.
// The byte window is a row of MAX_TAG_BYTES cells that shift once per accepted byte beat; each
// cell compares its incoming byte with both patterns, and the row's hits are combined in
// the same cycle.
// Throughput: one beat per cycle while rsp_if takes results. Latency: a result appears on rsp_if the cycle
// after the beat that causes it. Content bytes trail the input by the end-pattern length
// minus one, since they are held until they can no longer begin an end pattern.
// When rsp_if stalls, the output register holds its beat and req_if.ready drops until the
// beat is taken; any beat, with or without a result, is still accepted while the register is full
// and being drained.
// Reset: window empty, searching for a start pattern, both lengths one, both patterns zero.
`timescale 1ns / 1ps
`default_nettype none

module tag_delimited_record_extractor_core #(
   parameter int MAX_TAG_BYTES = 8
) (
   input  wire         clock,
   input  wire         reset,
   tdre_req_if.sink    req_if,
   tdre_rsp_if.source  rsp_if,
   tdre_csr_if.sink    csr_if
);

   localparam logic [tdre_pkg::TagLenW-1:0] MaxLen = tdre_pkg::TagLenW'(MAX_TAG_BYTES);

   tdre_pkg::tag_cfg_type    raw_cfg;
   tdre_pkg::tag_cfg_type    eff_cfg;
   tdre_pkg::cell_ctrl_type  ctrl;
   tdre_pkg::cell_stat_type  stat [MAX_TAG_BYTES];
   logic [7:0]               chain_byte [MAX_TAG_BYTES];
   logic                     chain_valid [MAX_TAG_BYTES];

   logic        inside_ff;
   logic        inside_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [1:0]  kind_ff;
   logic [1:0]  kind_in;
   logic [7:0]  content_ff;
   logic [7:0]  content_in;

   logic        accept;
   logic        start_match;
   logic        end_full;
   logic        end_match;
   logic [7:0]  out_byte;
   logic        has_result;

   tdre_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (raw_cfg)
   );

   always_comb begin
      eff_cfg           = raw_cfg;
      eff_cfg.start_len = tdre_pkg::eff_len(raw_cfg.start_len, MaxLen);
      eff_cfg.end_len   = tdre_pkg::eff_len(raw_cfg.end_len, MaxLen);
   end

   for (genvar i = 0; i < MAX_TAG_BYTES; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign chain_byte[i]  = req_if.data_byte;
         assign chain_valid[i] = 1'b1;
      end else begin : g_link
         assign chain_byte[i]  = stat[i-1].data;
         assign chain_valid[i] = stat[i-1].valid;
      end

      tdre_cell #(.CELL_INDEX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .byte_in  (chain_byte[i]),
         .valid_in (chain_valid[i]),
         .cfg      (eff_cfg),
         .ctrl     (ctrl),
         .stat     (stat[i])
      );
   end

   // Combine the row: window long enough, every cell hits
   always_comb begin
      logic start_full;
      logic start_all;
      logic end_all;
      start_full = 1'b0;
      start_all  = 1'b1;
      end_full   = 1'b0;
      end_all    = 1'b1;
      out_byte   = '0;
      for (int i = 0; i < MAX_TAG_BYTES; i++) begin
         start_all = start_all && stat[i].start_hit;
         end_all   = end_all && stat[i].end_hit;
         if (tdre_pkg::TagLenW'(i) == eff_cfg.start_len - 4'd1) start_full = chain_valid[i];
         if (tdre_pkg::TagLenW'(i) == eff_cfg.end_len - 4'd1) begin
            end_full = chain_valid[i];
            out_byte = chain_byte[i];
         end
      end
      start_match = start_full && start_all;
      end_match   = end_full && end_all;
   end

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      inside_in     = inside_ff;
      has_result    = 1'b0;
      kind_in       = kind_ff;
      content_in    = content_ff;
      ctrl.shift    = accept && !req_if.stream_end;
      ctrl.clear    = 1'b0;
      ctrl.trunc    = 1'b0;
      ctrl.keep_len = eff_cfg.end_len - 4'd1;
      if (accept) begin
         if (req_if.stream_end) begin
            inside_in  = 1'b0;
            ctrl.clear = 1'b1;
            if (inside_ff) begin
               has_result = 1'b1;
               kind_in    = tdre_pkg::KindUnterminated;
               content_in = '0;
            end
         end else if (!inside_ff) begin
            if (start_match) begin
               inside_in  = 1'b1;
               ctrl.clear = 1'b1;
            end
         end else if (end_full) begin
            has_result = 1'b1;
            if (end_match) begin
               inside_in  = 1'b0;
               ctrl.clear = 1'b1;
               kind_in    = tdre_pkg::KindRecordEnd;
               content_in = '0;
            end else begin
               // Oldest held byte can no longer start an end pattern: release it
               ctrl.trunc = 1'b1;
               kind_in    = tdre_pkg::KindContent;
               content_in = out_byte;
            end
         end
      end
      if (accept) rsp_valid_in = has_result;
      else        rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inside_ff    <= inside_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         kind_ff    <= kind_in;
         content_ff <= content_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_kind  = kind_ff;
   assign rsp_if.content_byte = content_ff;

endmodule

`default_nettype wire
